// ===== hdl/triangle_midpoint_subdivider_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_DEFINES_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled in reset.
`define TMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle rule");

`endif

// ===== hdl/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// Types, sizes and codes of the triangle midpoint subdivider.
// ----------------------------------------------------------------------------
`default_nettype none

package tms_pkg;

   localparam int MAX_VERTS = 1024;
   localparam int MAX_EDGES = 1024;
   localparam int COORD_W   = 16;
   localparam int VIDX_W    = $clog2(MAX_VERTS);
   localparam int EIDX_W    = $clog2(MAX_EDGES);
   localparam int VCNT_W    = VIDX_W + 1;
   localparam int ECNT_W    = EIDX_W + 1;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_TRI  = 2'd1;
   localparam logic [1:0] KIND_PASS = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EDGE_FULL = 2'd1;
   localparam logic [1:0] STATUS_VERT_FULL = 2'd2;

   localparam logic OUT_KIND_VERT = 1'b0;
   localparam logic OUT_KIND_TRI  = 1'b1;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [VIDX_W-1:0]         corner_a;
      logic [VIDX_W-1:0]         corner_b;
      logic [VIDX_W-1:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic                      out_kind;
      logic [VIDX_W-1:0]         vertex_index;
      logic [VIDX_W-1:0]         tri_a;
      logic [VIDX_W-1:0]         tri_b;
      logic [VIDX_W-1:0]         tri_c;
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] mid_z;
      logic [1:0]                status;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } coord3_type;

   typedef struct packed {
      logic [VIDX_W-1:0] lo;
      logic [VIDX_W-1:0] hi;
      logic [VIDX_W-1:0] mid;
   } edge_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_NEW,
      ST_RD_P,
      ST_RD_Q,
      ST_EMIT_MID,
      ST_NEXT,
      ST_TRI,
      ST_ERR
   } state_type;

   // Halved sum of two coordinates, rounding toward minus infinity.
   function automatic logic signed [COORD_W-1:0] half_sum(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      return s[COORD_W:1];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/triangle_midpoint_subdivider.sv =====
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider.
// Input channel req_*: load-vertex items append to the vertex store, new-pass
// items empty the edge table, triangle items are split into four. Result
// channel rsp_*: one item per new midpoint vertex, then four triangles, the
// last one marked; a full store or table ends the item with one error item.
// One item is worked on at a time; req_stall is high while it is in work.
// A load into a full store goes through ST_ERR for its error item. The edge
// lookup is a linear scan of the edge table through its single read port,
// and the midpoint reads both ends through the single vertex-store read
// port. An edge found missing from the table passes ST_NEW, ST_RD_P and
// ST_RD_Q before its midpoint result item is loaded in ST_EMIT_MID.
// Reset (synchronous, active high) empties vertex store and edge table by
// clearing their fill counts; no clearing pass is needed.
// When rsp_stall is high on a valid result, the result register holds and the sequencer waits in its emit states.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_midpoint_subdivider
   import tms_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   state_type state_ff, state_in;

   logic [VCNT_W-1:0] vcount_ff;
   logic [ECNT_W-1:0] ecount_ff;
   logic [ECNT_W-1:0] scan_ff;
   logic [1:0]        edge_sel_ff;
   logic [1:0]        tri_sel_ff;
   logic [VIDX_W-1:0] corner_ff [3];
   logic [VIDX_W-1:0] mid_ff    [3];
   logic [VIDX_W-1:0] p_ff, q_ff, lo_ff, hi_ff;
   logic [1:0]        err_code_ff;
   coord3_type        pcoord_ff;
   coord3_type        mcoord_ff;

   coord3_type        vmem [MAX_VERTS];
   coord3_type        vmem_rd_ff;
   edge_type          emem [MAX_EDGES];
   edge_type          emem_rd_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              req_accept;
   logic              rsp_free;
   logic              rsp_load;
   logic              vstore_full;
   logic              etable_full;
   logic              match;
   logic [VIDX_W-1:0] p_sel, q_sel;

   logic              vmem_we;
   logic [VIDX_W-1:0] vmem_waddr;
   coord3_type        vmem_wdata;
   logic [VIDX_W-1:0] vmem_raddr;
   logic              emem_we;
   rsp_type           rsp_next;

   assign req_accept  = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign vstore_full = vcount_ff >= VCNT_W'(MAX_VERTS);
   assign etable_full = ecount_ff >= ECNT_W'(MAX_EDGES);
   assign match       = (emem_rd_ff.lo == lo_ff) && (emem_rd_ff.hi == hi_ff);

   // Pick the ends of the current edge
   always_comb begin
      p_sel = corner_ff[0];
      q_sel = corner_ff[1];
      case (edge_sel_ff)
         2'd1: begin
            p_sel = corner_ff[1];
            q_sel = corner_ff[2];
         end
         2'd2: begin
            p_sel = corner_ff[2];
            q_sel = corner_ff[0];
         end
         default: begin
            p_sel = corner_ff[0];
            q_sel = corner_ff[1];
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.kind == KIND_TRI) begin
                  state_in = ST_EDGE;
               end else if (req_data.kind == KIND_LOAD && vstore_full) begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_EDGE:     state_in = ST_SCAN_RD;
         ST_SCAN_RD:  state_in = (scan_ff >= ecount_ff) ? ST_NEW : ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = match ? ST_NEXT : ST_SCAN_RD;
         ST_NEW:      state_in = (etable_full || vstore_full) ? ST_ERR : ST_RD_P;
         ST_RD_P:     state_in = ST_RD_Q;
         ST_RD_Q:     state_in = ST_EMIT_MID;
         ST_EMIT_MID: state_in = rsp_free ? ST_NEXT : ST_EMIT_MID;
         ST_NEXT:     state_in = (edge_sel_ff == 2'd2) ? ST_TRI : ST_EDGE;
         ST_TRI: begin
            if (rsp_free && tri_sel_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR:      state_in = rsp_free ? ST_IDLE : ST_ERR;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, memory strobes, result item
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      vmem_we    = 1'b0;
      vmem_waddr = vcount_ff[VIDX_W-1:0];
      vmem_wdata = {req_data.pos_x, req_data.pos_y, req_data.pos_z};
      vmem_raddr = p_ff;
      emem_we    = 1'b0;
      rsp_load   = 1'b0;
      rsp_next   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            vmem_we = req_accept && req_data.kind == KIND_LOAD && !vstore_full;
         end
         ST_RD_P: vmem_raddr = q_ff;
         ST_EMIT_MID: begin
            rsp_load   = rsp_free;
            vmem_we    = rsp_free;
            emem_we    = rsp_free;
            vmem_wdata = mcoord_ff;
            rsp_next.out_kind     = OUT_KIND_VERT;
            rsp_next.vertex_index = vcount_ff[VIDX_W-1:0];
            rsp_next.mid_x        = mcoord_ff.x;
            rsp_next.mid_y        = mcoord_ff.y;
            rsp_next.mid_z        = mcoord_ff.z;
            rsp_next.status       = STATUS_OK;
         end
         ST_TRI: begin
            rsp_load          = rsp_free;
            rsp_next.out_kind = OUT_KIND_TRI;
            rsp_next.status   = STATUS_OK;
            case (tri_sel_ff)
               2'd0: begin
                  rsp_next.tri_a = corner_ff[0];
                  rsp_next.tri_b = mid_ff[0];
                  rsp_next.tri_c = mid_ff[2];
               end
               2'd1: begin
                  rsp_next.tri_a = corner_ff[1];
                  rsp_next.tri_b = mid_ff[1];
                  rsp_next.tri_c = mid_ff[0];
               end
               2'd2: begin
                  rsp_next.tri_a = corner_ff[2];
                  rsp_next.tri_b = mid_ff[2];
                  rsp_next.tri_c = mid_ff[1];
               end
               default: begin
                  rsp_next.tri_a = mid_ff[0];
                  rsp_next.tri_b = mid_ff[1];
                  rsp_next.tri_c = mid_ff[2];
                  rsp_next.last  = 1'b1;
               end
            endcase
         end
         ST_ERR: begin
            rsp_load        = rsp_free;
            rsp_next.status = err_code_ff;
            rsp_next.last   = 1'b1;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Vertex store: one write and one registered read port
   always_ff @(posedge clock) begin
      if (vmem_we) begin
         vmem[vmem_waddr] <= vmem_wdata;
      end
      vmem_rd_ff <= vmem[vmem_raddr];
   end

   // Edge table: written at the fill count, read at the scan pointer
   always_ff @(posedge clock) begin
      if (emem_we) begin
         emem[ecount_ff[EIDX_W-1:0]] <= '{lo: lo_ff, hi: hi_ff, mid: vcount_ff[VIDX_W-1:0]};
      end
      emem_rd_ff <= emem[scan_ff[EIDX_W-1:0]];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         ecount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (vmem_we) begin
            vcount_ff <= vcount_ff + VCNT_W'(1);
         end
         if (emem_we) begin
            ecount_ff <= ecount_ff + ECNT_W'(1);
         end else if (state_ff == ST_IDLE && req_accept && req_data.kind == KIND_PASS) begin
            ecount_ff <= '0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
      case (state_ff)
         ST_IDLE: begin
            corner_ff[0] <= req_data.corner_a;
            corner_ff[1] <= req_data.corner_b;
            corner_ff[2] <= req_data.corner_c;
            edge_sel_ff  <= 2'd0;
            tri_sel_ff   <= 2'd0;
            err_code_ff  <= STATUS_VERT_FULL;
         end
         ST_EDGE: begin
            p_ff    <= p_sel;
            q_ff    <= q_sel;
            lo_ff   <= (p_sel < q_sel) ? p_sel : q_sel;
            hi_ff   <= (p_sel < q_sel) ? q_sel : p_sel;
            scan_ff <= '0;
         end
         ST_SCAN_CMP: begin
            if (match) begin
               mid_ff[edge_sel_ff] <= emem_rd_ff.mid;
            end
            scan_ff <= scan_ff + ECNT_W'(1);
         end
         ST_NEW: begin
            err_code_ff <= etable_full ? STATUS_EDGE_FULL : STATUS_VERT_FULL;
         end
         ST_RD_P: pcoord_ff <= vmem_rd_ff;
         ST_RD_Q: begin
            mcoord_ff.x <= half_sum(pcoord_ff.x, vmem_rd_ff.x);
            mcoord_ff.y <= half_sum(pcoord_ff.y, vmem_rd_ff.y);
            mcoord_ff.z <= half_sum(pcoord_ff.z, vmem_rd_ff.z);
         end
         ST_EMIT_MID: begin
            if (rsp_free) begin
               mid_ff[edge_sel_ff] <= vcount_ff[VIDX_W-1:0];
            end
         end
         ST_NEXT: edge_sel_ff <= edge_sel_ff + 2'd1;
         ST_TRI: begin
            if (rsp_free) begin
               tri_sel_ff <= tri_sel_ff + 2'd1;
            end
         end
         default: begin
            err_code_ff <= err_code_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/tms_checker.sv =====
// ----------------------------------------------------------------------------
// tms_checker
// Port-level checks of the triangle midpoint subdivider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_midpoint_subdivider_defines.svh"

module tms_checker
   import tms_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic rsp_waiting;
   logic tri_taken;
   logic rsp_err;
   logic rsp_tri;

   assign rsp_waiting = rsp_valid && rsp_stall;
   assign tri_taken   = req_valid && !req_stall && req_data.kind == KIND_TRI;
   assign rsp_err     = rsp_valid && rsp_data.status != STATUS_OK;
   assign rsp_tri     = rsp_valid && rsp_data.out_kind == OUT_KIND_TRI;

   // A stalled result item holds
   `TMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_data))

   // A triangle item keeps the input side busy
   `TMS_ASSERT_NEXT(a_tri_busy, clock, reset, tri_taken, req_stall)

   // An error item always ends its input item
   `TMS_ASSERT_NOW(a_err_last, clock, reset, rsp_err, rsp_data.last)

   // Triangles never carry an error status
   `TMS_ASSERT_NOW(a_tri_ok, clock, reset, rsp_tri, rsp_data.status == STATUS_OK)

endmodule

bind triangle_midpoint_subdivider tms_checker u_tms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/sv/tb_triangle_midpoint_subdivider.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_midpoint_subdivider
// Self-checking bench for the triangle midpoint subdivider. Items are sent on
// req_* with random gaps while idling is set. Each accepted item updates a
// local vertex store and edge table, and the results it should cause are
// queued. Every item taken from rsp_*, under random stall while idling is
// set, is checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_triangle_midpoint_subdivider;
   import tms_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Local copy of the block's state
   coord3_type vert_mem [MAX_VERTS];
   int         vert_fill;
   edge_type   edge_mem [MAX_EDGES];
   int         edge_fill;

   rsp_type pending_rsp [$];
   int      fail_count = 0;
   int      cycle_count = 0;
   bit      idling = 1'b1;
   int      hold_cnt = 0;

   triangle_midpoint_subdivider uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Halved sum, rounding toward minus infinity
   function automatic logic signed [COORD_W-1:0] mid_coord(
      input logic signed [COORD_W-1:0] p,
      input logic signed [COORD_W-1:0] q
   );
      logic signed [COORD_W:0] s;
      s = p + q;
      s = s >>> 1;
      return s[COORD_W-1:0];
   endfunction

   function automatic rsp_type error_rsp(input logic [1:0] code);
      rsp_type r;
      r = '0;
      r.status = code;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rsp_type tri_rsp(input int a, input int b, input int c, input bit fin);
      rsp_type r;
      r = '0;
      r.out_kind = OUT_KIND_TRI;
      r.tri_a = VIDX_W'(a);
      r.tri_b = VIDX_W'(b);
      r.tri_c = VIDX_W'(c);
      r.last = fin;
      return r;
   endfunction

   // Update the local state for one accepted item and queue its results
   task automatic subdivide_item(input req_type r);
      int         corner [3];
      int         mid [3];
      int         p, q, lo, hi, k;
      bit         found;
      coord3_type cp, cq, m;
      rsp_type    v;
      if (r.kind == KIND_LOAD) begin
         if (vert_fill >= MAX_VERTS) begin
            pending_rsp.push_back(error_rsp(STATUS_VERT_FULL));
         end else begin
            vert_mem[vert_fill] = '{r.pos_x, r.pos_y, r.pos_z};
            vert_fill++;
         end
         return;
      end
      if (r.kind == KIND_PASS) begin
         edge_fill = 0;
         return;
      end
      if (r.kind != KIND_TRI) return;
      corner[0] = r.corner_a;
      corner[1] = r.corner_b;
      corner[2] = r.corner_c;
      for (int e = 0; e < 3; e++) begin
         p = corner[e];
         q = corner[(e + 1) % 3];
         lo = (p < q) ? p : q;
         hi = (p < q) ? q : p;
         found = 1'b0;
         for (k = 0; k < edge_fill; k++) begin
            if (edge_mem[k].lo == lo && edge_mem[k].hi == hi) begin
               mid[e] = edge_mem[k].mid;
               found = 1'b1;
               break;
            end
         end
         if (!found) begin
            if (edge_fill >= MAX_EDGES) begin
               pending_rsp.push_back(error_rsp(STATUS_EDGE_FULL));
               return;
            end
            if (vert_fill >= MAX_VERTS) begin
               pending_rsp.push_back(error_rsp(STATUS_VERT_FULL));
               return;
            end
            cp = vert_mem[p];
            cq = vert_mem[q];
            m.x = mid_coord(cp.x, cq.x);
            m.y = mid_coord(cp.y, cq.y);
            m.z = mid_coord(cp.z, cq.z);
            vert_mem[vert_fill] = m;
            v = '0;
            v.out_kind = OUT_KIND_VERT;
            v.vertex_index = VIDX_W'(vert_fill);
            v.mid_x = m.x;
            v.mid_y = m.y;
            v.mid_z = m.z;
            v.status = STATUS_OK;
            pending_rsp.push_back(v);
            edge_mem[edge_fill] = '{VIDX_W'(lo), VIDX_W'(hi), VIDX_W'(vert_fill)};
            edge_fill++;
            mid[e] = vert_fill;
            vert_fill++;
         end
      end
      pending_rsp.push_back(tri_rsp(corner[0], mid[0], mid[2], 1'b0));
      pending_rsp.push_back(tri_rsp(corner[1], mid[1], mid[0], 1'b0));
      pending_rsp.push_back(tri_rsp(corner[2], mid[2], mid[1], 1'b0));
      pending_rsp.push_back(tri_rsp(mid[0], mid[1], mid[2], 1'b1));
   endtask

   // Send one item, after a random gap while idling is set, and hold it until accepted
   task automatic send_item(input req_type r);
      int gap;
      gap = idling ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      subdivide_item(r);
   endtask

   task automatic send_load(input int x, input int y, input int z);
      req_type r;
      r = '0;
      r.kind = KIND_LOAD;
      r.pos_x = COORD_W'(x);
      r.pos_y = COORD_W'(y);
      r.pos_z = COORD_W'(z);
      r.corner_a = VIDX_W'($urandom);
      r.corner_b = VIDX_W'($urandom);
      r.corner_c = VIDX_W'($urandom);
      send_item(r);
   endtask

   task automatic send_tri(input int a, input int b, input int c);
      req_type r;
      r = '0;
      r.kind = KIND_TRI;
      r.pos_x = COORD_W'($urandom);
      r.pos_y = COORD_W'($urandom);
      r.pos_z = COORD_W'($urandom);
      r.corner_a = VIDX_W'(a);
      r.corner_b = VIDX_W'(b);
      r.corner_c = VIDX_W'(c);
      send_item(r);
   endtask

   task automatic send_other(input logic [1:0] k);
      req_type r;
      r = '0;
      r.kind = k;
      r.pos_x = COORD_W'($urandom);
      r.pos_y = COORD_W'($urandom);
      r.pos_z = COORD_W'($urandom);
      r.corner_a = VIDX_W'($urandom);
      r.corner_b = VIDX_W'($urandom);
      r.corner_c = VIDX_W'($urandom);
      send_item(r);
   endtask

   // Hold the sender until every queued result has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Extreme coordinates, shared and reversed edges, degenerate edges, an unused kind, a new pass
   task automatic test_directed();
      send_load(32767, -32768, 0);
      send_load(32767, 32767, -1);
      send_load(-32768, -32768, 1);
      send_load(-1, 1, -32768);
      send_load(0, -1, 32767);
      send_tri(0, 1, 2);
      send_tri(2, 1, 0);
      send_tri(3, 3, 0);
      send_tri(4, 4, 4);
      send_other(KIND_UNUSED);
      send_tri(1, 3, 4);
      send_other(KIND_PASS);
      send_tri(0, 1, 2);
      send_tri(2, 3, 4);
      drain_results();
   endtask

   // Mostly small meshes between passes, some noise
   task automatic test_random_mesh();
      int pool [6];
      int pick;
      for (int i = 0; i < 6; i++) pool[i] = $urandom_range(0, vert_fill - 1);
      for (int n = 0; n < 265; n++) begin
         if (n == 80) idling = 1'b0;
         if (n == 130) idling = 1'b1;
         if (n == 160) drain_results();
         pick = $urandom_range(0, 99);
         if (edge_fill > 30 || pick < 6) begin
            send_other(KIND_PASS);
            for (int i = 0; i < 6; i++) pool[i] = $urandom_range(0, vert_fill - 1);
         end else if (pick < 10) begin
            send_other(KIND_UNUSED);
         end else if (pick < 30 || vert_fill > 900) begin
            if (vert_fill < 900) send_load($urandom, $urandom, $urandom);
            else send_other(KIND_PASS);
         end else if (pick < 40) begin
            send_tri($urandom_range(0, vert_fill - 1), $urandom_range(0, vert_fill - 1),
                     $urandom_range(0, vert_fill - 1));
         end else begin
            send_tri(pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)],
                     pool[$urandom_range(0, 5)]);
         end
      end
      drain_results();
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Take results under random stall and compare with the oldest expected
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("result with none expected: %h", rsp_data);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("out_kind", 16'(want.out_kind), 16'(rsp_data.out_kind));
               check_field("vertex_index", 16'(want.vertex_index),
                           16'(rsp_data.vertex_index));
               check_field("tri_a", 16'(want.tri_a), 16'(rsp_data.tri_a));
               check_field("tri_b", 16'(want.tri_b), 16'(rsp_data.tri_b));
               check_field("tri_c", 16'(want.tri_c), 16'(rsp_data.tri_c));
               check_field("mid_x", 16'(want.mid_x), 16'(rsp_data.mid_x));
               check_field("mid_y", 16'(want.mid_y), 16'(rsp_data.mid_y));
               check_field("mid_z", 16'(want.mid_z), 16'(rsp_data.mid_z));
               check_field("status", 16'(want.status), 16'(rsp_data.status));
               check_field("last", 16'(want.last), 16'(rsp_data.last));
            end
            hold_cnt = idling ? $urandom_range(0, 10) : 0;
         end else if (hold_cnt > 0) begin
            hold_cnt--;
         end
         rsp_stall <= (hold_cnt > 0);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      vert_fill = 0;
      edge_fill = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mesh();
      if (pending_rsp.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
